>>> hdl/set_assoc_lru_cache_model_core_macros.svh
// Assertion macros for the cache model core.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_CORE_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SALC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("salc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SALC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("salc: next-cycle check failed");

`endif

>>> hdl/salc_pkg.sv
package salc_pkg;

    // Field widths of the item payloads.
    localparam int MODE_W  = 2;
    localparam int ADDR_W  = 64;
    localparam int TAG_W   = 64;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 32;
    localparam int SIDX_W  = 6;

    // Configuration register widths and the port layout.
    localparam int SET_BITS_W = 3;
    localparam int OFF_BITS_W = 6;
    localparam int WAYS_W     = 4;
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_SET_BITS    = 2'd0;
    localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
    localparam logic [1:0] REG_WAYS_IN_USE = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [SET_BITS_W-1:0] SET_BITS_RST = 3'd4;
    localparam logic [OFF_BITS_W-1:0] OFF_BITS_RST = 6'd4;
    localparam logic [WAYS_W-1:0]     WAYS_RST     = 4'd1;

    // Largest offset that is honoured.
    localparam logic [OFF_BITS_W-1:0] OFF_BITS_MAX = 6'd32;

    // Access modes.
    localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STORE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MODIFY = 2'd2;
    localparam logic [MODE_W-1:0] MODE_IFETCH = 2'd3;

    // One cache line as held in a set row.
    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } way_t;

    localparam int WAY_W = $bits(way_t);

endpackage

>>> hdl/salc_req_if.sv
interface salc_req_if;
    logic                        valid;
    logic                        ready;
    logic [salc_pkg::MODE_W-1:0] mode;
    logic [salc_pkg::ADDR_W-1:0] address;

    modport source (output valid, output mode, output address, input ready);
    modport sink   (input valid, input mode, input address, output ready);
endinterface

>>> hdl/salc_rsp_if.sv
interface salc_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         hit;
    logic                         evicted;
    logic [salc_pkg::SIDX_W-1:0]  set_index;
    logic [salc_pkg::TAG_W-1:0]   line_tag;
    logic [salc_pkg::TAG_W-1:0]   evicted_tag;
    logic [salc_pkg::CNT_W-1:0]   hit_total;
    logic [salc_pkg::CNT_W-1:0]   miss_total;
    logic [salc_pkg::CNT_W-1:0]   eviction_total;
    logic                         last;

    modport source (output valid, output hit, output evicted, output set_index,
                    output line_tag, output evicted_tag, output hit_total,
                    output miss_total, output eviction_total, output last,
                    input ready);
    modport sink   (input valid, input hit, input evicted, input set_index,
                    input line_tag, input evicted_tag, input hit_total,
                    input miss_total, input eviction_total, input last,
                    output ready);
endinterface

>>> hdl/salc_set_ram.sv
// Set row memory: one write port and one read port, read data registered.
module salc_set_ram #(
    parameter int DEPTH  = 64,
    parameter int AW     = 6,
    parameter int DATA_W = 776
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, enabled by re; the read data is registered.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/set_assoc_lru_cache_model_core.sv
// Tag-only set-associative cache model with least-recently-used replacement. Each set is one
// row of a synchronous memory holding the valid bit, tag and last-use stamp of every way, and
// each lookup reads that row, compares the tag across the ways and picks the replacement
// candidates, then writes the row back and loads the output register; that last step waits
// while the output register holds a result that has not been taken. A modify makes two
// lookups and two results. The input is taken again once the sequencer is back in idle, so a
// load or store holds it until its write-back and a modify until its second write-back; an
// instruction fetch, which makes no lookup and no result, is taken without leaving idle. The
// second lookup of a modify rereads the row after the first write-back, so it always sees the
// updated line. After reset a clearing pass zeroes all 2**MAX_SET_BITS rows while no item is
// accepted; configuration writes through the APB port are taken at any time.
`include "set_assoc_lru_cache_model_core_macros.svh"

module set_assoc_lru_cache_model_core #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [salc_pkg::PADDR_W-1:0]   paddr,
    input  logic [salc_pkg::PDATA_W-1:0]   pwdata,
    output logic [salc_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready,
    salc_req_if.sink                       req,
    salc_rsp_if.source                     rsp
);

    localparam int SET_W      = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int NUM_SETS   = 1 << MAX_SET_BITS;
    localparam int WAY_IDX_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int ROW_W      = MAX_WAYS * salc_pkg::WAY_W;
    localparam int LRU_LEAVES = 1 << WAY_IDX_W;
    localparam int LRU_NODES  = 2 * LRU_LEAVES - 1;

    typedef salc_pkg::way_t [MAX_WAYS-1:0] row_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_COMMIT,
        ST_REREAD
    } state_t;

    state_t state_reg;

    // Configuration registers.
    logic [salc_pkg::SET_BITS_W-1:0] set_bits_reg;
    logic [salc_pkg::OFF_BITS_W-1:0] offset_bits_reg;
    logic [salc_pkg::WAYS_W-1:0]     ways_in_use_reg;

    // Lookup context and statistics.
    logic [SET_W-1:0]                set_reg;
    logic [salc_pkg::SIDX_W-1:0]     set_index_reg;
    logic [salc_pkg::TAG_W-1:0]      tag_reg;
    logic                            second_reg;
    logic [SET_W-1:0]                clr_cnt_reg;
    logic [salc_pkg::STAMP_W-1:0]    access_clock_reg;
    logic [salc_pkg::CNT_W-1:0]      hit_cnt_reg;
    logic [salc_pkg::CNT_W-1:0]      miss_cnt_reg;
    logic [salc_pkg::CNT_W-1:0]      evict_cnt_reg;

    // Results of the compare cycle.
    logic                            hit_reg;
    logic [WAY_IDX_W-1:0]            hit_way_reg;
    logic                            have_inv_reg;
    logic [WAY_IDX_W-1:0]            inv_way_reg;
    logic [WAY_IDX_W-1:0]            lru_way_reg;

    // Output register.
    logic                            out_valid_reg;
    logic                            out_hit_reg;
    logic                            out_evicted_reg;
    logic [salc_pkg::SIDX_W-1:0]     out_set_index_reg;
    logic [salc_pkg::TAG_W-1:0]      out_line_tag_reg;
    logic [salc_pkg::TAG_W-1:0]      out_evicted_tag_reg;
    logic [salc_pkg::CNT_W-1:0]      out_hit_total_reg;
    logic [salc_pkg::CNT_W-1:0]      out_miss_total_reg;
    logic [salc_pkg::CNT_W-1:0]      out_eviction_total_reg;
    logic                            out_last_reg;

    // Memory port signals.
    logic                            ram_we;
    logic [SET_W-1:0]                ram_waddr;
    logic [ROW_W-1:0]                ram_wdata;
    logic                            ram_re;
    logic [SET_W-1:0]                ram_raddr;
    logic [ROW_W-1:0]                ram_rdata;

    // Address decode signals.
    logic [3:0]                      sb;
    logic [salc_pkg::OFF_BITS_W-1:0] ob;
    logic [4:0]                      nw;
    logic [6:0]                      tshift;
    logic [salc_pkg::ADDR_W-1:0]     set_wide;
    logic [salc_pkg::TAG_W-1:0]      tag_in;

    // Compare and write-back signals.
    row_t                            rd_row;
    row_t                            new_row;
    logic                            hit_found;
    logic [WAY_IDX_W-1:0]            hit_way;
    logic                            inv_found;
    logic [WAY_IDX_W-1:0]            inv_way;
    logic [WAY_IDX_W-1:0]            lru_way;
    logic                            lru_have [LRU_NODES];
    logic [salc_pkg::STAMP_W-1:0]    lru_st   [LRU_NODES];
    logic [WAY_IDX_W-1:0]            lru_idx  [LRU_NODES];
    logic [WAY_IDX_W-1:0]            victim;
    logic                            ev;
    logic [salc_pkg::TAG_W-1:0]      ev_tag;
    logic [salc_pkg::STAMP_W-1:0]    stamp_next;
    logic [salc_pkg::CNT_W-1:0]      hit_cnt_next;
    logic [salc_pkg::CNT_W-1:0]      miss_cnt_next;
    logic [salc_pkg::CNT_W-1:0]      evict_cnt_next;
    logic                            lookup_accept;
    logic                            commit_go;

    // Handshake decode.
    assign req.ready     = (state_reg == ST_IDLE);
    assign lookup_accept = req.valid && (state_reg == ST_IDLE)
                           && (req.mode != salc_pkg::MODE_IFETCH);
    assign commit_go     = (state_reg == ST_COMMIT) && (!out_valid_reg || rsp.ready);

    // APB register port; the configuration is meant to change only while the block is idle.
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg    <= salc_pkg::SET_BITS_RST;
            offset_bits_reg <= salc_pkg::OFF_BITS_RST;
            ways_in_use_reg <= salc_pkg::WAYS_RST;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                salc_pkg::REG_SET_BITS:    set_bits_reg    <= pwdata[salc_pkg::SET_BITS_W-1:0];
                salc_pkg::REG_OFFSET_BITS: offset_bits_reg <= pwdata[salc_pkg::OFF_BITS_W-1:0];
                salc_pkg::REG_WAYS_IN_USE: ways_in_use_reg <= pwdata[salc_pkg::WAYS_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            salc_pkg::REG_SET_BITS:    prdata = salc_pkg::PDATA_W'(set_bits_reg);
            salc_pkg::REG_OFFSET_BITS: prdata = salc_pkg::PDATA_W'(offset_bits_reg);
            salc_pkg::REG_WAYS_IN_USE: prdata = salc_pkg::PDATA_W'(ways_in_use_reg);
            default:                   prdata = '0;
        endcase
    end

    // Clamp the configuration and split the incoming address into set and tag.
    always_comb
    begin
        sb = (4'(set_bits_reg) > 4'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : 4'(set_bits_reg);
        ob = (offset_bits_reg > salc_pkg::OFF_BITS_MAX) ? salc_pkg::OFF_BITS_MAX
                                                         : offset_bits_reg;
        if (ways_in_use_reg == '0)
        begin
            nw = 5'd1;
        end
        else if (5'(ways_in_use_reg) > 5'(MAX_WAYS))
        begin
            nw = 5'(MAX_WAYS);
        end
        else
        begin
            nw = 5'(ways_in_use_reg);
        end
        tshift   = 7'(ob) + 7'(sb);
        set_wide = (req.address >> ob) & ((64'd1 << sb) - 64'd1);
        tag_in   = (tshift >= 7'd64) ? '0 : (req.address >> tshift);
    end

    // Compare the tag across the ways in use and find the replacement candidates. The oldest
    // stamp is found by a tree of compares in which the lower way wins on equal stamps.
    always_comb
    begin
        rd_row    = row_t'(ram_rdata);
        hit_found = 1'b0;
        hit_way   = '0;
        inv_found = 1'b0;
        inv_way   = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (5'(w) < nw)
            begin
                if (rd_row[w].valid && (rd_row[w].tag == tag_reg) && !hit_found)
                begin
                    hit_found = 1'b1;
                    hit_way   = WAY_IDX_W'(w);
                end
                if (!rd_row[w].valid && !inv_found)
                begin
                    inv_found = 1'b1;
                    inv_way   = WAY_IDX_W'(w);
                end
            end
        end

        // Leaves of the tree; ways outside the count in use take no part.
        for (int w = 0; w < LRU_LEAVES; w++)
        begin
            lru_have[LRU_LEAVES - 1 + w] = 1'b0;
            lru_st[LRU_LEAVES - 1 + w]   = '0;
            lru_idx[LRU_LEAVES - 1 + w]  = WAY_IDX_W'(w);
        end
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            lru_have[LRU_LEAVES - 1 + w] = (5'(w) < nw);
            lru_st[LRU_LEAVES - 1 + w]   = rd_row[w].stamp;
        end

        // Each node keeps the older of its two children, the left one on a tie.
        for (int n = LRU_LEAVES - 2; n >= 0; n--)
        begin
            if (lru_have[2*n + 2]
                && (!lru_have[2*n + 1] || (lru_st[2*n + 2] < lru_st[2*n + 1])))
            begin
                lru_have[n] = 1'b1;
                lru_st[n]   = lru_st[2*n + 2];
                lru_idx[n]  = lru_idx[2*n + 2];
            end
            else
            begin
                lru_have[n] = lru_have[2*n + 1];
                lru_st[n]   = lru_st[2*n + 1];
                lru_idx[n]  = lru_idx[2*n + 1];
            end
        end
        lru_way = lru_idx[0];
    end

    // Build the written-back row and the next statistics.
    always_comb
    begin
        stamp_next = access_clock_reg + 1'b1;
        if (hit_reg)
        begin
            victim = hit_way_reg;
        end
        else if (have_inv_reg)
        begin
            victim = inv_way_reg;
        end
        else
        begin
            victim = lru_way_reg;
        end
        ev             = !hit_reg && !have_inv_reg;
        ev_tag         = ev ? rd_row[victim].tag : '0;
        new_row        = rd_row;
        new_row[victim].valid = 1'b1;
        new_row[victim].tag   = tag_reg;
        new_row[victim].stamp = stamp_next;
        hit_cnt_next   = hit_cnt_reg + (hit_reg ? 32'd1 : 32'd0);
        miss_cnt_next  = miss_cnt_reg + (hit_reg ? 32'd0 : 32'd1);
        evict_cnt_next = evict_cnt_reg + (ev ? 32'd1 : 32'd0);
    end

    // Memory port control.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = set_reg;
        ram_wdata = ROW_W'(new_row);
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else if (commit_go)
        begin
            ram_we = 1'b1;
        end
        ram_re    = lookup_accept || (state_reg == ST_REREAD);
        ram_raddr = (state_reg == ST_REREAD) ? set_reg : set_wide[SET_W-1:0];
    end

    salc_set_ram #(
        .DEPTH  (NUM_SETS),
        .AW     (SET_W),
        .DATA_W (ROW_W)
    ) u_set_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer, statistics and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_cnt_reg      <= '0;
            second_reg       <= 1'b0;
            access_clock_reg <= '0;
            hit_cnt_reg      <= '0;
            miss_cnt_reg     <= '0;
            evict_cnt_reg    <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (commit_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (clr_cnt_reg == SET_W'(NUM_SETS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (lookup_accept)
                    begin
                        set_reg       <= set_wide[SET_W-1:0];
                        set_index_reg <= set_wide[salc_pkg::SIDX_W-1:0];
                        tag_reg       <= tag_in;
                        second_reg    <= (req.mode == salc_pkg::MODE_MODIFY);
                        state_reg     <= ST_EVAL;
                    end
                end
                ST_EVAL:
                begin
                    hit_reg      <= hit_found;
                    hit_way_reg  <= hit_way;
                    have_inv_reg <= inv_found;
                    inv_way_reg  <= inv_way;
                    lru_way_reg  <= lru_way;
                    state_reg    <= ST_COMMIT;
                end
                ST_COMMIT:
                begin
                    if (commit_go)
                    begin
                        access_clock_reg       <= stamp_next;
                        hit_cnt_reg            <= hit_cnt_next;
                        miss_cnt_reg           <= miss_cnt_next;
                        evict_cnt_reg          <= evict_cnt_next;
                        out_hit_reg            <= hit_reg;
                        out_evicted_reg        <= ev;
                        out_set_index_reg      <= set_index_reg;
                        out_line_tag_reg       <= tag_reg;
                        out_evicted_tag_reg    <= ev_tag;
                        out_hit_total_reg      <= hit_cnt_next;
                        out_miss_total_reg     <= miss_cnt_next;
                        out_eviction_total_reg <= evict_cnt_next;
                        out_last_reg           <= !second_reg;
                        second_reg             <= 1'b0;
                        state_reg              <= second_reg ? ST_REREAD : ST_IDLE;
                    end
                end
                ST_REREAD:
                begin
                    state_reg <= ST_EVAL;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Result channel.
    assign rsp.valid          = out_valid_reg;
    assign rsp.hit            = out_hit_reg;
    assign rsp.evicted        = out_evicted_reg;
    assign rsp.set_index      = out_set_index_reg;
    assign rsp.line_tag       = out_line_tag_reg;
    assign rsp.evicted_tag    = out_evicted_tag_reg;
    assign rsp.hit_total      = out_hit_total_reg;
    assign rsp.miss_total     = out_miss_total_reg;
    assign rsp.eviction_total = out_eviction_total_reg;
    assign rsp.last           = out_last_reg;

    // Checks on the sequencer and the statistics.
    `SALC_ASSERT_IMP(a_write_phase, ram_we, (state_reg == ST_COMMIT) || (state_reg == ST_CLEAR))
    `SALC_ASSERT_NXT(a_read_then_eval, lookup_accept, state_reg == ST_EVAL)
    `SALC_ASSERT_NXT(a_lookup_count, commit_go,
        (hit_cnt_reg + miss_cnt_reg) == ($past(hit_cnt_reg) + $past(miss_cnt_reg) + 32'd1))
    `SALC_ASSERT_IMP(a_evict_consistent, rsp.valid,
        !(rsp.hit && rsp.evicted) && (rsp.evicted || (rsp.evicted_tag == 64'd0)))

endmodule
